>>> rtl/dbciv_pkg.sv
// Shared constants, types and tables for the timestamp to civil date converter.
// Used by db_datetime_to_civil_core and tb_top; depends on nothing else.
package dbciv_pkg;

  // Time field scales.
  localparam int TICKS_PER_HOUR   = 1080000;
  localparam int TICKS_PER_MINUTE = 18000;
  localparam int TICKS_PER_SECOND = 300;
  localparam int TICKS_PER_FRACT  = 3;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int BASE_YEAR        = 1900;

  // Gregorian cycle lengths, counted from a year that starts on March 1.
  localparam int DAYS_PER_ERA   = 146097;
  localparam int LAST_DOE       = 146096;
  localparam int DAYS_PER_CENT  = 36524;
  localparam int DAYS_PER_4Y    = 1460;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int YEARS_PER_CENT = 100;
  localparam int YEARS_PER_ERA  = 400;
  localparam int MONTH_SPAN     = 153;

  // Day count of the last date the year field can hold, and the shift from
  // days after 1900-01-01 to days after 0000-03-01.
  localparam int MAX_DAY_COUNT = 5290171;
  localparam int EPOCH_SHIFT   = 693901;

  // Width of a day count after the carried days are added.
  localparam int DAY_W = 23;

  // Latency of one constant divider.
  localparam int CDIV_LAT = 3;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] fraction;
  } tod_t;

  // First day of each month within a March-based year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

>>> rtl/dbciv_cdiv.sv
// Pipelined division of an unsigned value by a constant, with a sideband
// that travels alongside. Three register stages; uses no package.
module dbciv_cdiv #(
  parameter int IN_W    = 32,
  parameter int DIVISOR = 3,
  parameter int Q_W     = 8,
  parameter int R_W     = 2,
  parameter int SIDE_W  = 1
) (
  input  logic              clk,
  input  logic [IN_W-1:0]   x,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    q,
  output logic [R_W-1:0]    r,
  output logic [SIDE_W-1:0] side_out
);

  localparam longint unsigned RECIP = (64'd1 << IN_W) / DIVISOR;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [IN_W-1:0]    DIV_X   = IN_W'(DIVISOR);
  localparam logic [R_W:0]       DIV_R   = (R_W + 1)'(DIVISOR);

  logic [PROD_W-1:0] prod;
  logic [IN_W-1:0]   back;
  logic [IN_W-1:0]   diff;
  logic [IN_W-1:0]   x_a;
  logic [Q_W-1:0]    q_a;
  logic [Q_W-1:0]    q_b;
  logic [R_W:0]      r_b;
  logic [SIDE_W-1:0] side_a;
  logic [SIDE_W-1:0] side_b;

  // The truncated reciprocal makes the estimate at most one below the true
  // quotient, so the remainder lands below twice the divisor.
  assign prod = PROD_W'(x) * PROD_W'(RECIP_C);
  assign back = IN_W'(q_a * DIV_X);
  assign diff = x_a - back;

  always_ff @(posedge clk) begin
    x_a    <= x;
    q_a    <= Q_W'(prod >> IN_W);
    side_a <= side_in;

    q_b    <= q_a;
    r_b    <= (R_W + 1)'(diff);
    side_b <= side_a;

    if (r_b >= DIV_R) begin
      q <= q_b + Q_W'(1);
      r <= R_W'(r_b - DIV_R);
    end else begin
      q <= q_b;
      r <= R_W'(r_b);
    end
    side_out <= side_b;
  end

endmodule

>>> rtl/db_datetime_to_civil_core.sv
// Timestamp to Gregorian date and time converter, top level.
// Depends on dbciv_pkg and dbciv_cdiv.
//
// Usage: drive operation, days_since_1900 and time_of_day and raise start.
// A transaction is taken at each rising edge where start is high and busy is
// low. busy is high only while rst is asserted, so outside reset a new
// transaction can be started in every cycle.
// operation 0 reads time_of_day as 1/300 s ticks, operation 1 as minutes;
// whole days beyond 24 hours are carried into the date, and dates past
// 16383-12-31 saturate to that day.
// Each result appears on year, month, day_of_month, hour, minute, second and
// fraction for exactly one cycle with done high, in the same order as the
// transactions. Throughput is one result per cycle.
// The pipeline is a chain of seven three-stage constant dividers (hours, days,
// era, four-year and century, year of era, century of era, month) plus five
// register stages; the minute, second and fraction dividers run beside it.
// Results cannot be held off: the downstream must take each one when done
// is high. Reset (synchronous) clears the done pipeline only; transactions
// in flight at reset are dropped.
module db_datetime_to_civil_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [21:0] days_since_1900,
  input  logic [31:0] time_of_day,
  output logic        done,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [6:0]  fraction
);

  localparam int PIPE_LAT = 7 * dbciv_pkg::CDIV_LAT + 5;
  localparam int DW = dbciv_pkg::DAY_W;

  logic [PIPE_LAT-1:0] vld;

  // Input register.
  logic        op_in;
  logic [21:0] days_in;
  logic [31:0] tod_in;

  // Hours from the time field.
  logic [11:0] hf_q;
  logic [20:0] hf_r;
  logic [26:0] hs_q;
  logic [5:0]  hs_r;
  logic [21:0] g1_days;
  logic        g1_op;
  logic [26:0] hours;
  logic [20:0] ticks;

  // Carried days, hour of day, minute.
  logic [21:0] carry_q;
  logic [4:0]  hour_r;
  logic [21:0] g2_days;
  logic [5:0]  min_q;
  logic [14:0] min_r;
  logic [6:0]  g2_side;
  logic [DW-1:0] day_sum;

  logic [DW-1:0] z;
  logic [14:0]   r0_ticks;
  logic [4:0]    r0_hour;
  logic [5:0]    r0_minute;
  logic          r0_op;

  // Second and era.
  logic [5:0]  sec_q;
  logic [8:0]  sec_r;
  logic [10:0] g3_hm;
  logic [5:0]  era_q;
  logic [17:0] doe_r;
  logic        g3_op;

  // Fraction and the leap corrections within an era.
  logic [6:0]  frac_q;
  logic [17:0] g4_side;
  logic [6:0]  q4y;
  logic [17:0] g4_doe;
  logic [2:0]  qcent;
  logic [5:0]  g4_era;

  logic [17:0]          r1_num;
  logic [17:0]          r1_doe;
  logic [5:0]           r1_era;
  dbciv_pkg::tod_t      r1_time;

  // Year of era and century of era.
  logic [8:0]  yoe_q;
  logic [47:0] g5_side;
  logic [1:0]  cy_q;
  logic [56:0] g6_side;
  logic [8:0]  g6_yoe;
  logic [5:0]  g6_era;
  logic [17:0] g6_doe;
  logic [17:0] yr_days;

  logic [8:0]           r2_doy;
  logic [8:0]           r2_yoe;
  logic [5:0]           r2_era;
  dbciv_pkg::tod_t      r2_time;

  // Month within the March-based year.
  logic [10:0]     mp_in;
  logic [3:0]      mp_q;
  logic [47:0]     g7_side;
  logic [8:0]      g7_doy;
  logic [8:0]      g7_yoe;
  logic [5:0]      g7_era;
  dbciv_pkg::tod_t g7_time;
  logic [8:0]      dom;
  logic [13:0]     year_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    op_in   <= operation;
    days_in <= days_since_1900;
    tod_in  <= time_of_day;
  end

  dbciv_cdiv #(
    .IN_W(32), .DIVISOR(dbciv_pkg::TICKS_PER_HOUR), .Q_W(12), .R_W(21), .SIDE_W(22)
  ) u_div_hf (
    .clk, .x(tod_in), .side_in(days_in), .q(hf_q), .r(hf_r), .side_out(g1_days)
  );

  dbciv_cdiv #(
    .IN_W(32), .DIVISOR(dbciv_pkg::MINUTES_PER_HOUR), .Q_W(27), .R_W(6), .SIDE_W(1)
  ) u_div_hs (
    .clk, .x(tod_in), .side_in(op_in), .q(hs_q), .r(hs_r), .side_out(g1_op)
  );

  assign hours = g1_op ? hs_q : 27'(hf_q);
  assign ticks = g1_op ? '0 : hf_r;

  dbciv_cdiv #(
    .IN_W(27), .DIVISOR(dbciv_pkg::HOURS_PER_DAY), .Q_W(22), .R_W(5), .SIDE_W(22)
  ) u_div_day (
    .clk, .x(hours), .side_in(g1_days), .q(carry_q), .r(hour_r), .side_out(g2_days)
  );

  dbciv_cdiv #(
    .IN_W(21), .DIVISOR(dbciv_pkg::TICKS_PER_MINUTE), .Q_W(6), .R_W(15), .SIDE_W(7)
  ) u_div_min (
    .clk, .x(ticks), .side_in({g1_op, hs_r}), .q(min_q), .r(min_r), .side_out(g2_side)
  );

  assign day_sum = DW'(g2_days) + DW'(carry_q);

  always_ff @(posedge clk) begin
    if (day_sum > DW'(dbciv_pkg::MAX_DAY_COUNT)) begin
      z <= DW'(dbciv_pkg::MAX_DAY_COUNT + dbciv_pkg::EPOCH_SHIFT);
    end else begin
      z <= day_sum + DW'(dbciv_pkg::EPOCH_SHIFT);
    end
    r0_ticks  <= min_r;
    r0_hour   <= hour_r;
    r0_minute <= g2_side[6] ? g2_side[5:0] : min_q;
    r0_op     <= g2_side[6];
  end

  dbciv_cdiv #(
    .IN_W(15), .DIVISOR(dbciv_pkg::TICKS_PER_SECOND), .Q_W(6), .R_W(9), .SIDE_W(11)
  ) u_div_sec (
    .clk, .x(r0_ticks), .side_in({r0_hour, r0_minute}), .q(sec_q), .r(sec_r),
    .side_out(g3_hm)
  );

  dbciv_cdiv #(
    .IN_W(DW), .DIVISOR(dbciv_pkg::DAYS_PER_ERA), .Q_W(6), .R_W(18), .SIDE_W(1)
  ) u_div_era (
    .clk, .x(z), .side_in(r0_op), .q(era_q), .r(doe_r), .side_out(g3_op)
  );

  dbciv_cdiv #(
    .IN_W(9), .DIVISOR(dbciv_pkg::TICKS_PER_FRACT), .Q_W(7), .R_W(2), .SIDE_W(18)
  ) u_div_frac (
    .clk, .x(sec_r), .side_in({g3_op, g3_hm, sec_q}), .q(frac_q), .r(),
    .side_out(g4_side)
  );

  dbciv_cdiv #(
    .IN_W(18), .DIVISOR(dbciv_pkg::DAYS_PER_4Y), .Q_W(7), .R_W(11), .SIDE_W(18)
  ) u_div_4y (
    .clk, .x(doe_r), .side_in(doe_r), .q(q4y), .r(), .side_out(g4_doe)
  );

  dbciv_cdiv #(
    .IN_W(18), .DIVISOR(dbciv_pkg::DAYS_PER_CENT), .Q_W(3), .R_W(16), .SIDE_W(6)
  ) u_div_cent (
    .clk, .x(doe_r), .side_in(era_q), .q(qcent), .r(), .side_out(g4_era)
  );

  // The short format has no seconds; its second and fraction read as zero.
  always_ff @(posedge clk) begin
    r1_num <= g4_doe - 18'(q4y) + 18'(qcent)
              - 18'(g4_doe == 18'(dbciv_pkg::LAST_DOE));
    r1_doe <= g4_doe;
    r1_era <= g4_era;
    r1_time.hour     <= g4_side[16:12];
    r1_time.minute   <= g4_side[11:6];
    r1_time.second   <= g4_side[17] ? '0 : g4_side[5:0];
    r1_time.fraction <= g4_side[17] ? '0 : frac_q;
  end

  dbciv_cdiv #(
    .IN_W(18), .DIVISOR(dbciv_pkg::DAYS_PER_YEAR), .Q_W(9), .R_W(9), .SIDE_W(48)
  ) u_div_yoe (
    .clk, .x(r1_num), .side_in({r1_era, r1_doe, r1_time}), .q(yoe_q), .r(),
    .side_out(g5_side)
  );

  dbciv_cdiv #(
    .IN_W(9), .DIVISOR(dbciv_pkg::YEARS_PER_CENT), .Q_W(2), .R_W(7), .SIDE_W(57)
  ) u_div_cy (
    .clk, .x(yoe_q), .side_in({yoe_q, g5_side}), .q(cy_q), .r(), .side_out(g6_side)
  );

  assign g6_yoe = g6_side[56:48];
  assign g6_era = g6_side[47:42];
  assign g6_doe = g6_side[41:24];

  // Days before the start of this year within the era.
  assign yr_days = 18'(g6_yoe) * 18'(dbciv_pkg::DAYS_PER_YEAR) + 18'(g6_yoe[8:2])
                   - 18'(cy_q);

  always_ff @(posedge clk) begin
    r2_doy  <= 9'(g6_doe - yr_days);
    r2_yoe  <= g6_yoe;
    r2_era  <= g6_era;
    r2_time <= g6_side[23:0];
  end

  assign mp_in = 11'(r2_doy) * 11'd5 + 11'd2;

  dbciv_cdiv #(
    .IN_W(11), .DIVISOR(dbciv_pkg::MONTH_SPAN), .Q_W(4), .R_W(8), .SIDE_W(48)
  ) u_div_mp (
    .clk, .x(mp_in), .side_in({r2_doy, r2_yoe, r2_era, r2_time}), .q(mp_q), .r(),
    .side_out(g7_side)
  );

  assign g7_doy  = g7_side[47:39];
  assign g7_yoe  = g7_side[38:30];
  assign g7_era  = g7_side[29:24];
  assign g7_time = g7_side[23:0];

  assign dom = g7_doy - dbciv_pkg::month_start(mp_q) + 9'd1;

  // January and February belong to the next calendar year.
  assign year_next = 14'(dbciv_pkg::BASE_YEAR - dbciv_pkg::BASE_YEAR) + 14'(g7_yoe)
                     + 14'(g7_era) * 14'(dbciv_pkg::YEARS_PER_ERA)
                     + 14'(mp_q >= 4'd10);

  always_ff @(posedge clk) begin
    year         <= year_next;
    month        <= (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
    day_of_month <= 5'(dom);
    hour         <= g7_time.hour;
    minute       <= g7_time.minute;
    second       <= g7_time.second;
    fraction     <= g7_time.fraction;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result without a matching transaction");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
              && day_of_month <= 5'd31))
    else $error("month or day out of range");

  a_year_floor: assert property (@(posedge clk) disable iff (rst)
    done |-> year >= 14'(dbciv_pkg::BASE_YEAR))
    else $error("year below base year");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
              && fraction <= 7'd99))
    else $error("time field out of range");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for db_datetime_to_civil_core: directed and random timestamps
// in both time formats, each result checked against a date and time predictor.
// Depends on dbciv_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit OP_FULL  = 1'b0;  // time of day in 1/300 s ticks
  localparam bit OP_SHORT = 1'b1;  // time of day in minutes

  localparam int unsigned LAST_LISTED_DAY = 2958463;
  localparam int unsigned TICKS_PER_DAY   = 25920000;
  localparam int unsigned MINUTES_PER_DAY = 1440;
  // Minutes that carry the largest day count onto the last representable date.
  localparam int unsigned SAT_EDGE_MIN    = 1578049920;
  localparam int unsigned DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [13:0]     year;
    logic [3:0]      month;
    logic [4:0]      day_of_month;
    dbciv_pkg::tod_t tod;
  } civil_t;

  class civil_scoreboard;
    civil_t      due_q[$];
    int unsigned errors    = 0;
    int unsigned checked   = 0;
    int unsigned saturated = 0;
    int unsigned n_full    = 0;
    int unsigned n_short   = 0;

    function civil_t civil_of(bit op, bit [21:0] days, bit [31:0] tod);
      longint unsigned hours, rest, mins, secs, frac;
      longint unsigned count, z, era, doe, yoe, doy, mp, yy, mm, dd;
      civil_t r;
      secs = 0;
      frac = 0;
      if (op == OP_FULL) begin
        hours = tod / dbciv_pkg::TICKS_PER_HOUR;
        rest  = tod - hours * dbciv_pkg::TICKS_PER_HOUR;
        mins  = rest / dbciv_pkg::TICKS_PER_MINUTE;
        rest  = rest - mins * dbciv_pkg::TICKS_PER_MINUTE;
        secs  = rest / dbciv_pkg::TICKS_PER_SECOND;
        rest  = rest - secs * dbciv_pkg::TICKS_PER_SECOND;
        frac  = rest / dbciv_pkg::TICKS_PER_FRACT;
      end else begin
        hours = tod / dbciv_pkg::MINUTES_PER_HOUR;
        mins  = tod - hours * dbciv_pkg::MINUTES_PER_HOUR;
      end
      count = days + hours / dbciv_pkg::HOURS_PER_DAY;
      if (count > dbciv_pkg::MAX_DAY_COUNT) begin
        count = dbciv_pkg::MAX_DAY_COUNT;
        saturated++;
      end
      // Civil date from a day count in a calendar whose years start on March 1.
      z   = count + dbciv_pkg::EPOCH_SHIFT;
      era = z / dbciv_pkg::DAYS_PER_ERA;
      doe = z - era * dbciv_pkg::DAYS_PER_ERA;
      yoe = (doe - doe / dbciv_pkg::DAYS_PER_4Y + doe / dbciv_pkg::DAYS_PER_CENT
             - doe / dbciv_pkg::LAST_DOE) / dbciv_pkg::DAYS_PER_YEAR;
      doy = doe - (dbciv_pkg::DAYS_PER_YEAR * yoe + yoe / 4
                   - yoe / dbciv_pkg::YEARS_PER_CENT);
      mp  = (5 * doy + 2) / dbciv_pkg::MONTH_SPAN;
      yy  = yoe + era * dbciv_pkg::YEARS_PER_ERA;
      dd  = doy - (dbciv_pkg::MONTH_SPAN * mp + 2) / 5 + 1;
      mm  = (mp < 10) ? mp + 3 : mp - 9;
      if (mm <= 2) yy++;
      r.year         = yy[13:0];
      r.month        = mm[3:0];
      r.day_of_month = dd[4:0];
      r.tod.hour     = 5'(hours % dbciv_pkg::HOURS_PER_DAY);
      r.tod.minute   = mins[5:0];
      r.tod.second   = secs[5:0];
      r.tod.fraction = frac[6:0];
      return r;
    endfunction

    function void note(bit op, bit [21:0] days, bit [31:0] tod);
      due_q.push_back(civil_of(op, days, tod));
      if (op == OP_FULL) n_full++;
      else n_short++;
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
    endfunction

    function void check(civil_t got);
      civil_t exp;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending, actual %0d-%0d-%0d", $time,
                 got.year, got.month, got.day_of_month);
        return;
      end
      exp = due_q.pop_front();
      checked++;
      compare_field("year", exp.year, got.year);
      compare_field("month", exp.month, got.month);
      compare_field("day_of_month", exp.day_of_month, got.day_of_month);
      compare_field("hour", exp.tod.hour, got.tod.hour);
      compare_field("minute", exp.tod.minute, got.tod.minute);
      compare_field("second", exp.tod.second, got.tod.second);
      compare_field("fraction", exp.tod.fraction, got.tod.fraction);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = OP_FULL;
  logic [21:0] days_since_1900 = '0;
  logic [31:0] time_of_day = '0;
  logic        done;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [6:0]  fraction;

  civil_scoreboard sb = new();
  int unsigned     sender_idle_pct = 0;

  db_datetime_to_civil_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .days_since_1900(days_since_1900),
    .time_of_day    (time_of_day),
    .done           (done),
    .year           (year),
    .month          (month),
    .day_of_month   (day_of_month),
    .hour           (hour),
    .minute         (minute),
    .second         (second),
    .fraction       (fraction)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Inputs and outputs are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    civil_t got;
    if (!rst) begin
      if (start && !busy) sb.note(operation, days_since_1900, time_of_day);
      if (done) begin
        got.year         = year;
        got.month        = month;
        got.day_of_month = day_of_month;
        got.tod          = '{hour, minute, second, fraction};
        sb.check(got);
      end
    end
  end

  task automatic send_stamp(input bit op, input bit [21:0] days, input bit [31:0] tod);
    start           <= 1'b1;
    operation       <= op;
    days_since_1900 <= days;
    time_of_day     <= tod;
    do @(posedge clk); while (busy);
    // Idle cycles carry junk on the payload to show it is ignored without start.
    while ($urandom_range(99) < sender_idle_pct) begin
      start           <= 1'b0;
      operation       <= 1'($urandom);
      days_since_1900 <= 22'($urandom);
      time_of_day     <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic send_random_stamp();
    bit          op;
    bit [21:0]   days;
    bit [31:0]   tod;
    int unsigned pick;
    op   = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) days = 22'($urandom_range(LAST_LISTED_DAY));
    else if (pick < 92) days = 22'($urandom);
    else if (pick < 96) days = '0;
    else days = '1;
    pick = $urandom_range(99);
    if (op == OP_FULL) begin
      if (pick < 70) tod = $urandom_range(TICKS_PER_DAY - 1);
      else if (pick < 88) tod = $urandom;
      else tod = $urandom_range(dbciv_pkg::TICKS_PER_HOUR);
    end else begin
      if (pick < 55) tod = $urandom_range(MINUTES_PER_DAY - 1);
      else if (pick < 70) tod = $urandom_range(MINUTES_PER_DAY * 400);
      else if (pick < 85) tod = $urandom;
      else begin
        // Straddle the point where the date saturates.
        days = '1;
        tod  = SAT_EDGE_MIN - MINUTES_PER_DAY + $urandom_range(2 * MINUTES_PER_DAY);
      end
    end
    send_stamp(op, days, tod);
  endtask

  initial begin
    int unsigned idle_plan[3];
    idle_plan = '{29, 67, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Field extremes, leap and century edges, carried days and date saturation.
    send_stamp(OP_FULL, 22'd0, 32'd0);
    send_stamp(OP_SHORT, 22'd0, 32'd0);
    send_stamp(OP_FULL, 22'd58, 32'd299);
    send_stamp(OP_FULL, 22'd59, 32'd296);
    send_stamp(OP_FULL, 22'd36583, 32'd17999);
    send_stamp(OP_FULL, 22'd36584, 32'd1079999);
    send_stamp(OP_FULL, 22'd36890, TICKS_PER_DAY - 1);
    send_stamp(OP_FULL, 22'd36890, TICKS_PER_DAY);
    send_stamp(OP_FULL, 22'(LAST_LISTED_DAY), TICKS_PER_DAY - 1);
    send_stamp(OP_FULL, 22'(LAST_LISTED_DAY), 32'hFFFF_FFFF);
    send_stamp(OP_FULL, 22'h3F_FFFF, 32'hFFFF_FFFF);
    send_stamp(OP_SHORT, 22'd400, MINUTES_PER_DAY - 1);
    send_stamp(OP_SHORT, 22'd400, MINUTES_PER_DAY);
    send_stamp(OP_SHORT, 22'(LAST_LISTED_DAY), 32'd59);
    send_stamp(OP_SHORT, 22'h3F_FFFF, SAT_EDGE_MIN - 1);
    send_stamp(OP_SHORT, 22'h3F_FFFF, SAT_EDGE_MIN);
    send_stamp(OP_SHORT, 22'h3F_FFFF, SAT_EDGE_MIN + MINUTES_PER_DAY);
    send_stamp(OP_SHORT, 22'h3F_FFFF, 32'hFFFF_FFFF);
    send_stamp(OP_SHORT, 22'h15_5555, 32'hAAAA_AAAA);
    send_stamp(OP_FULL, 22'h2A_AAAA, 32'h5555_5555);

    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      repeat (230) send_random_stamp();
    end
    start <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.due_q.size());
    end

    $display("Converted %0d full-format and %0d short-format timestamps, %0d results checked,",
             sb.n_full, sb.n_short, sb.checked);
    $display("%0d of them clamped to the last representable date; %0d errors.",
             sb.saturated, sb.errors);
    if (sb.errors == 0) begin
      $display("db_datetime_to_civil_core regression: pass");
    end else begin
      $display("db_datetime_to_civil_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", sb.due_q.size());
    $display("db_datetime_to_civil_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/dbciv_pkg.sv
rtl/dbciv_cdiv.sv
rtl/db_datetime_to_civil_core.sv
dv/tb_top.sv
